@@ sv/cgds_pkg.sv @@
// ============================================================================
// cgds_pkg
// Shared constants, types and helpers for the coverage grid disc stamp.
// ============================================================================
`default_nettype none

package cgds_pkg;

  // Grid geometry and stamp shape
  localparam int GRID_WIDTH      = 2048;
  localparam int GRID_HEIGHT     = 2048;
  localparam int CELLS_PER_METRE = 25;
  localparam int STAMP_HALF      = 5;
  localparam int CELL_MAX        = 100;

  // Fixed field widths
  localparam int CELL_W     = 7;
  localparam int POS_W      = 16;
  localparam int FRAC_W     = 8;
  localparam int IN_CELL_W  = 11;
  localparam int STEP_W     = 8;
  localparam int RAD_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int OUT_CNT_W  = 7;

  // Derived sizes
  localparam int GRID_DEPTH = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W     = $clog2(GRID_DEPTH);
  localparam int COL_W      = $clog2(GRID_WIDTH);
  localparam int ROW_W      = $clog2(GRID_HEIGHT);
  localparam int GRID_MAX   = (GRID_WIDTH > GRID_HEIGHT) ? GRID_WIDTH : GRID_HEIGHT;

  localparam int WIN        = 2 * STAMP_HALF + 1;
  localparam int WIN_CELLS  = WIN * WIN;
  localparam int CNT_W      = $clog2(WIN_CELLS + 1);
  localparam int OFS_W      = $clog2(STAMP_HALF + 1) + 1;
  localparam int DIST_W     = $clog2(2 * STAMP_HALF * STAMP_HALF + 1);

  localparam int ROUND_HALF = 1 << (FRAC_W - 1);
  localparam int MAG_MAX    = (1 << (POS_W - 1)) * CELLS_PER_METRE + ROUND_HALF;
  localparam int MAG_W      = $clog2(MAG_MAX + 1);
  localparam int R_MAX      = MAG_MAX >> FRAC_W;
  localparam int CRD_MAX    = R_MAX + GRID_MAX / 2 + STAMP_HALF + GRID_MAX;
  localparam int CRD_W_RAW  = $clog2(CRD_MAX + 1) + 1;
  localparam int CRD_W      = (CRD_W_RAW > IN_CELL_W + 1) ? CRD_W_RAW : IN_CELL_W + 1;

  localparam int SUM_W      = STEP_W + 2;

  // Command and reply codes
  localparam logic FUNC_STAMP  = 1'b0;
  localparam logic FUNC_READ   = 1'b1;
  localparam logic REPLY_STAMP = 1'b0;
  localparam logic REPLY_READ  = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INSIDE_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTSIDE_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQ    = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CENTRE,
    ST_START,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic signed [STEP_W-1:0] inside_step;
    logic signed [STEP_W-1:0] outside_step;
    logic [RAD_W-1:0]         radius_sq;
  } cfg_t;

  typedef struct packed {
    logic                    start;
    logic                    single;
    logic signed [CRD_W-1:0] cx;
    logic signed [CRD_W-1:0] cy;
  } walk_cmd_t;

  typedef struct packed {
    logic              vld;
    logic              modify;
    logic              in_disc;
    logic [ADDR_W-1:0] addr;
  } cell_req_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] count;
  } walk_stat_t;

  typedef struct packed {
    logic              clearing;
    logic              busy;
    logic              rd_strobe;
    logic [CELL_W-1:0] rd_value;
  } rmw_stat_t;

  // Q7.8 metres to whole cells, rounded half away from zero
  function automatic logic signed [CRD_W-1:0] to_cells(input logic signed [POS_W-1:0] p);
    logic [POS_W:0]   mag;
    logic [MAG_W-1:0] prod;
    logic [CRD_W-1:0] r;
    mag  = p[POS_W-1] ? ((POS_W + 1)'(0) - {p[POS_W-1], p}) : {1'b0, p};
    prod = MAG_W'(mag) * MAG_W'(CELLS_PER_METRE);
    r    = CRD_W'((prod + MAG_W'(ROUND_HALF)) >> FRAC_W);
    return p[POS_W-1] ? -$signed(r) : $signed(r);
  endfunction

endpackage

`default_nettype wire

@@ sv/coverage_grid_disc_stamp.sv @@
// ============================================================================
// coverage_grid_disc_stamp
// Coverage grid with disc stamping: keeps a grid of 0..100 cells in one RAM
// and either stamps a disc around a scaled position or reads back one cell.
// ============================================================================
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  input   | start / busy         | in_func, in_pos_x, in_pos_y, in_cell_col,
//          |                      | in_cell_row
//  result  | out_valid (strobe)   | out_reply_kind, out_cell_value,
//          |                      | out_cells_written
//  config  | cfg_we               | cfg_index, cfg_wdata
//
//  A transaction is taken when start is high and busy is low.
//  Stamp: after acceptance the position is scaled and centred, then the window
//  walk issues one cell read-modify-write a cycle on the single grid RAM and the
//  result strobe follows once the walk has drained. Read: only the addressed cell.
//  After reset a clearing pass writes zero to every cell, one per cycle; busy
//  holds high meanwhile, config writes are still taken.
//  The result strobe lasts one cycle; the receiver cannot stall it.
//
`default_nettype none

module coverage_grid_disc_stamp import cgds_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_func,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic [IN_CELL_W-1:0]    in_cell_col,
  input  logic [IN_CELL_W-1:0]    in_cell_row,
  // result channel
  output logic                    out_valid,
  output logic                    out_reply_kind,
  output logic [CELL_W-1:0]       out_cell_value,
  output logic [OUT_CNT_W-1:0]    out_cells_written,
  // config port
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  state_t state_r, state_nxt;

  cfg_t cfg_r;

  // command held for the transaction in flight
  logic                    func_r;
  logic signed [POS_W-1:0] pos_x_r, pos_y_r;
  logic signed [CRD_W-1:0] cx_r, cy_r;
  logic [CELL_W-1:0]       value_r;

  // result registers
  logic                    out_valid_r;
  logic                    out_kind_r;
  logic [CELL_W-1:0]       out_value_r;
  logic [OUT_CNT_W-1:0]    out_cnt_r;

  logic accept, load_centre, finish, drained;

  walk_cmd_t  walk_cmd;
  cell_req_t  cell_req;
  walk_stat_t walk_stat;
  rmw_stat_t  rmw_stat;

  // --------------------------------------------------------------------------
  // Configuration registers: writes beyond the list are dropped
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inside_step  <= STEP_W'(2);
      cfg_r.outside_step <= STEP_W'(0);
      cfg_r.radius_sq    <= RAD_W'(9);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INSIDE_STEP:  cfg_r.inside_step  <= cfg_wdata[STEP_W-1:0];
        CFG_OUTSIDE_STEP: cfg_r.outside_step <= cfg_wdata[STEP_W-1:0];
        CFG_RADIUS_SQ:    cfg_r.radius_sq    <= cfg_wdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  // The pipeline is empty once the walker and the write-back stage are idle;
  // only then is the last cell safely in the RAM.
  assign drained = !walk_stat.busy && !rmw_stat.busy;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (!rmw_stat.clearing) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_nxt = (in_func == FUNC_READ) ? ST_START : ST_CENTRE;
      end
      ST_CENTRE: state_nxt = ST_START;
      ST_START:  state_nxt = ST_DRAIN;
      ST_DRAIN: begin
        if (drained) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    accept          = (state_r == ST_IDLE) && start;
    load_centre     = (state_r == ST_CENTRE);
    finish          = (state_r == ST_DRAIN) && drained;
    walk_cmd.start  = (state_r == ST_START);
    walk_cmd.single = (func_r == FUNC_READ);
    walk_cmd.cx     = cx_r;
    walk_cmd.cy     = cy_r;
    busy            = (state_r != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= finish;
    end
  end

  // Capture the transaction; a read uses the cell coordinates as the centre.
  // A stamp scales and centres its position in the following cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= in_func;
      pos_x_r <= in_pos_x;
      pos_y_r <= in_pos_y;
      cx_r    <= CRD_W'(in_cell_col);
      cy_r    <= CRD_W'(in_cell_row);
      value_r <= '0;
    end else begin
      if (load_centre) begin
        cx_r <= to_cells(pos_x_r) + $signed(CRD_W'(GRID_WIDTH / 2));
        cy_r <= to_cells(pos_y_r) + $signed(CRD_W'(GRID_HEIGHT / 2));
      end
      if (rmw_stat.rd_strobe) begin
        value_r <= rmw_stat.rd_value;
      end
    end
  end

  // Load the result for its one-cycle strobe
  always_ff @(posedge clk) begin
    if (finish) begin
      out_kind_r  <= (func_r == FUNC_READ) ? REPLY_READ : REPLY_STAMP;
      out_value_r <= (func_r == FUNC_READ) ? value_r : '0;
      out_cnt_r   <= (func_r == FUNC_READ) ? '0 : OUT_CNT_W'(walk_stat.count);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_reply_kind    = out_kind_r;
  assign out_cell_value    = out_value_r;
  assign out_cells_written = out_cnt_r;

  // --------------------------------------------------------------------------
  // Datapath: window walker feeding the read-modify-write stage
  // --------------------------------------------------------------------------
  cgds_walk u_walk (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (walk_cmd),
    .cfg   (cfg_r),
    .req   (cell_req),
    .stat  (walk_stat)
  );

  cgds_rmw u_rmw (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cell_req),
    .cfg   (cfg_r),
    .stat  (rmw_stat)
  );

  a_strobe_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == ST_DRAIN))
    else $error("result strobe without a finished transaction");

  a_read_data_for_read: assert property (@(posedge clk) disable iff (!rst_n)
    rmw_stat.rd_strobe |-> (func_r == FUNC_READ) && (state_r == ST_DRAIN))
    else $error("read data returned outside a read transaction");

endmodule

`default_nettype wire

@@ sv/cgds_ram.sv @@
// ============================================================================
// cgds_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module cgds_ram #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ sv/cgds_walk.sv @@
// ============================================================================
// cgds_walk
// Window walker: steps over the stamp window (or the centre cell alone), one
// cell a cycle, and turns each in-grid cell into a grid address and disc flag.
// ============================================================================
`default_nettype none

module cgds_walk import cgds_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  walk_cmd_t  cmd,
  input  cfg_t       cfg,
  output cell_req_t  req,
  output walk_stat_t stat
);

  logic                    act_r, act_nxt;
  logic                    single_r, single_nxt;
  logic signed [CRD_W-1:0] cx_r, cx_nxt;
  logic signed [CRD_W-1:0] cy_r, cy_nxt;
  logic signed [OFS_W-1:0] dx_r, dx_nxt;
  logic signed [OFS_W-1:0] dy_r, dy_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;

  logic                    b_vld_r, b_mod_r, b_in_r;
  logic [COL_W-1:0]        b_col_r;
  logic [ROW_W-1:0]        b_row_r;
  cell_req_t               req_r, req_nxt;

  logic signed [CRD_W-1:0]   xx, yy;
  logic                      in_grid;
  logic signed [2*OFS_W-1:0] dx_sq, dy_sq;
  logic [DIST_W-1:0]         dist_sq;
  logic                      last;

  always_comb begin
    xx      = cx_r + {{(CRD_W - OFS_W){dx_r[OFS_W-1]}}, dx_r};
    yy      = cy_r + {{(CRD_W - OFS_W){dy_r[OFS_W-1]}}, dy_r};
    in_grid = act_r && !xx[CRD_W-1] && !yy[CRD_W-1]
              && (xx < $signed(CRD_W'(GRID_WIDTH)))
              && (yy < $signed(CRD_W'(GRID_HEIGHT)));
    dx_sq   = dx_r * dx_r;
    dy_sq   = dy_r * dy_r;
    dist_sq = dx_sq[DIST_W-1:0] + dy_sq[DIST_W-1:0];
    last    = single_r || ((dx_r == OFS_W'(STAMP_HALF)) && (dy_r == OFS_W'(STAMP_HALF)));
  end

  // Walk counters: dy inner, dx outer
  always_comb begin
    act_nxt    = act_r;
    single_nxt = single_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    cnt_nxt    = cnt_r;
    if (cmd.start) begin
      act_nxt    = 1'b1;
      single_nxt = cmd.single;
      cx_nxt     = cmd.cx;
      cy_nxt     = cmd.cy;
      dx_nxt     = cmd.single ? OFS_W'(0) : OFS_W'(-STAMP_HALF);
      dy_nxt     = cmd.single ? OFS_W'(0) : OFS_W'(-STAMP_HALF);
      cnt_nxt    = '0;
    end else if (act_r) begin
      if (in_grid) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      if (last) begin
        act_nxt = 1'b0;
      end else if (dy_r == OFS_W'(STAMP_HALF)) begin
        dy_nxt = OFS_W'(-STAMP_HALF);
        dx_nxt = dx_r + OFS_W'(1);
      end else begin
        dy_nxt = dy_r + OFS_W'(1);
      end
    end
  end

  always_comb begin
    req_nxt.vld     = b_vld_r;
    req_nxt.modify  = b_mod_r;
    req_nxt.in_disc = b_in_r;
    req_nxt.addr    = ADDR_W'(b_row_r) * ADDR_W'(GRID_WIDTH) + ADDR_W'(b_col_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r     <= 1'b0;
      cnt_r     <= '0;
      b_vld_r   <= 1'b0;
      req_r.vld <= 1'b0;
    end else begin
      act_r     <= act_nxt;
      cnt_r     <= cnt_nxt;
      b_vld_r   <= in_grid;
      req_r     <= req_nxt;
    end
  end

  always_ff @(posedge clk) begin
    single_r      <= single_nxt;
    cx_r          <= cx_nxt;
    cy_r          <= cy_nxt;
    dx_r          <= dx_nxt;
    dy_r          <= dy_nxt;
    b_mod_r       <= !single_r;
    b_in_r        <= (32'(dist_sq) <= 32'(cfg.radius_sq));
    b_col_r       <= xx[COL_W-1:0];
    b_row_r       <= yy[ROW_W-1:0];
  end

  assign req        = req_r;
  assign stat.busy  = act_r | b_vld_r | req_r.vld;
  assign stat.count = cnt_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= WIN_CELLS)
    else $error("walk count beyond window size");

endmodule

`default_nettype wire

@@ sv/cgds_rmw.sv @@
// ============================================================================
// cgds_rmw
// Read-modify-write of grid cells on the coverage RAM, plus the clearing
// pass that zeroes the grid after reset.
// ============================================================================
`default_nettype none

module cgds_rmw import cgds_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_req_t req,
  input  cfg_t      cfg,
  output rmw_stat_t stat
);

  logic              clr_act_r, clr_act_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  logic              d_vld_r, d_mod_r, d_in_r;
  logic [ADDR_W-1:0] d_addr_r;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [CELL_W-1:0] ram_rdata;

  logic signed [STEP_W-1:0] step;
  logic signed [SUM_W-1:0]  sum;
  logic [CELL_W-1:0]        new_val;

  always_comb begin
    clr_act_nxt  = clr_act_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_act_r) begin
      clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(GRID_DEPTH - 1)) begin
        clr_act_nxt = 1'b0;
      end
    end
  end

  // Add the step and clamp to the cell range
  always_comb begin
    step = d_in_r ? cfg.inside_step : cfg.outside_step;
    sum  = $signed({{(SUM_W - CELL_W){1'b0}}, ram_rdata})
         + $signed({{(SUM_W - STEP_W){step[STEP_W-1]}}, step});
    if (sum < 0) begin
      new_val = '0;
    end else if (sum > $signed(SUM_W'(CELL_MAX))) begin
      new_val = CELL_W'(CELL_MAX);
    end else begin
      new_val = sum[CELL_W-1:0];
    end
  end

  always_comb begin
    if (clr_act_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = d_vld_r && d_mod_r;
      ram_waddr = d_addr_r;
      ram_wdata = new_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_act_r  <= 1'b1;
      clr_addr_r <= '0;
      d_vld_r    <= 1'b0;
    end else begin
      clr_act_r  <= clr_act_nxt;
      clr_addr_r <= clr_addr_nxt;
      d_vld_r    <= req.vld;
    end
  end

  always_ff @(posedge clk) begin
    d_mod_r  <= req.modify;
    d_in_r   <= req.in_disc;
    d_addr_r <= req.addr;
  end

  cgds_ram #(
    .DEPTH  (GRID_DEPTH),
    .DATA_W (CELL_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (req.vld),
    .rd_addr (req.addr),
    .rd_data (ram_rdata)
  );

  assign stat.clearing  = clr_act_r;
  assign stat.busy      = d_vld_r;
  assign stat.rd_strobe = d_vld_r && !d_mod_r;
  assign stat.rd_value  = ram_rdata;

  a_no_read_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_act_r |-> !req.vld)
    else $error("cell read during clearing pass");

  a_no_same_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (d_vld_r && d_mod_r && req.vld) |-> (req.addr != d_addr_r))
    else $error("read and write-back hit the same cell");

  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && !clr_act_r) |-> (32'(ram_wdata) <= CELL_MAX))
    else $error("write-back value out of range");

endmodule

`default_nettype wire
